// ===== design/ple_pkg.sv =====
`timescale 1ns / 1ps

package ple_pkg;

    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 3;
    localparam int LEN_W    = 7;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_INS_POS   = 3'd2,
        CMD_REM_FRONT = 3'd3,
        CMD_REM_BACK  = 3'd4,
        CMD_REM_POS   = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE   = 3'd0,
        ST_EMPTY  = 3'd1,
        ST_RANGE  = 3'd2,
        ST_FULL   = 3'd3,
        ST_SINGLE = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } cell_op_t;

    // broadcast to every cell of the row
    typedef struct packed {
        cell_op_t                   op;
        logic signed [VALUE_W-1:0]  value;
    } cell_ctl_t;

endpackage

// ===== design/ple_cell.sv =====
`timescale 1ns / 1ps

module ple_cell #(
    parameter int IDX_W = 6,
    parameter int INDEX = 0
) (
    input  logic                                aclk,
    input  ple_pkg::cell_ctl_t                  ctl,
    input  logic [IDX_W-1:0]                    at,
    input  logic signed [ple_pkg::VALUE_W-1:0]  left_data,
    input  logic signed [ple_pkg::VALUE_W-1:0]  right_data,
    output logic signed [ple_pkg::VALUE_W-1:0]  data
);
    import ple_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic signed [VALUE_W-1:0] data_reg;
    logic signed [VALUE_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        case (ctl.op)
            OP_INSERT: begin
                // cells behind the slot take their front neighbor
                if (MY_IDX > at) begin
                    data_next = left_data;
                end else if (MY_IDX == at) begin
                    data_next = ctl.value;
                end
            end
            OP_REMOVE: begin
                if (MY_IDX >= at) begin
                    data_next = right_data;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== design/ple_ctrl.sv =====
`timescale 1ns / 1ps

module ple_ctrl #(
    parameter int CAPACITY = 64,
    parameter int CNT_W    = 7,
    parameter int IDX_W    = 6
) (
    input  logic                                fire,
    input  ple_pkg::cmd_t                       cmd,
    input  logic signed [ple_pkg::VALUE_W-1:0]  value,
    input  logic [ple_pkg::POS_W-1:0]           pos,
    input  logic [CNT_W-1:0]                    count,
    output ple_pkg::status_t                    status,
    output logic [CNT_W-1:0]                    count_next,
    output ple_pkg::cell_ctl_t                  ctl,
    output logic [IDX_W-1:0]                    at
);
    import ple_pkg::*;

    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] at_wide;
    logic             is_full;
    logic             is_empty;
    cell_op_t         op;

    assign cnt_ext  = CMP_W'(count);
    assign pos_ext  = CMP_W'(pos);
    assign is_full  = (count == CNT_W'(CAPACITY));
    assign is_empty = (count == '0);

    always_comb begin
        status  = ST_DONE;
        op      = OP_HOLD;
        at_wide = '0;
        case (cmd)
            CMD_INS_FRONT: begin
                if (is_full) status = ST_FULL;
                else op = OP_INSERT;
            end
            CMD_INS_BACK: begin
                at_wide = cnt_ext;
                if (is_full) status = ST_FULL;
                else op = OP_INSERT;
            end
            CMD_INS_POS: begin
                at_wide = pos_ext;
                if (is_full) status = ST_FULL;
                else if (pos_ext > cnt_ext) status = ST_RANGE;
                else op = OP_INSERT;
            end
            CMD_REM_FRONT: begin
                if (is_empty) status = ST_EMPTY;
                else op = OP_REMOVE;
            end
            CMD_REM_BACK: begin
                at_wide = cnt_ext - CMP_W'(1);
                if (is_empty) status = ST_EMPTY;
                else if (count == CNT_W'(1)) status = ST_SINGLE;
                else op = OP_REMOVE;
            end
            CMD_REM_POS: begin
                at_wide = pos_ext;
                if (is_empty) status = ST_EMPTY;
                else if (pos_ext >= cnt_ext) status = ST_RANGE;
                else op = OP_REMOVE;
            end
            default: begin
                status = ST_DONE;
            end
        endcase
    end

    always_comb begin
        count_next = count;
        ctl.op     = OP_HOLD;
        ctl.value  = value;
        if (fire) begin
            ctl.op = op;
            if (op == OP_INSERT) count_next = count + CNT_W'(1);
            else if (op == OP_REMOVE) count_next = count - CNT_W'(1);
        end
    end

    assign at = at_wide[IDX_W-1:0];

endmodule

// ===== design/positional_list_engine_top.sv =====
`timescale 1ns / 1ps

// positional list engine: keeps an ordered list of up to CAPACITY signed
// 32-bit values in a row of cells, front at cell 0. each input word carries
// one command (insert front, back or at a position, remove front, back or at
// a position) and yields exactly one result word with a status code and the
// list length after the command. all cells shift toward the back (insert) or
// the front (remove) of the chosen slot in the same edge, so the row updates
// as a whole and a new command can be taken every cycle. the result sits in
// an output register; a new command is accepted whenever that register is
// empty or being read in the same cycle, so the throughput is one command
// per cycle with m_tready high. rejected commands (full, empty, out of range,
// single entry on back remove) and unused command codes leave the list
// unchanged.
module positional_list_engine_top #(
    parameter int CAPACITY = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // command channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [2:0] command, [34:3] value, [41:35] position, [47:42] zero
    input  logic [ple_pkg::S_DATA_W-1:0]   s_tdata,
    // result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [2:0] status, [9:3] length, [15:10] zero
    output logic [ple_pkg::M_DATA_W-1:0]   m_tdata
);
    import ple_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    // fields of the incoming word
    cmd_t                       in_cmd;
    logic signed [VALUE_W-1:0]  in_value;
    logic [POS_W-1:0]           in_pos;

    assign in_cmd   = cmd_t'(s_tdata[CMD_W-1:0]);
    assign in_value = s_tdata[CMD_W+VALUE_W-1:CMD_W];
    assign in_pos   = s_tdata[CMD_W+VALUE_W+POS_W-1:CMD_W+VALUE_W];

    logic fire;

    // list length
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // result register
    logic             valid_reg;
    logic             valid_next;
    status_t          status_reg;
    status_t          status_next;
    logic [LEN_W-1:0] length_reg;

    cell_ctl_t        ctl;
    logic [IDX_W-1:0] at;

    // accept while the result register is free or drains this cycle
    assign s_tready = !valid_reg || m_tready;
    assign fire     = s_tvalid && s_tready;

    ple_ctrl #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W),
        .IDX_W    (IDX_W)
    ) u_ctrl (
        .fire       (fire),
        .cmd        (in_cmd),
        .value      (in_value),
        .pos        (in_pos),
        .count      (count_reg),
        .status     (status_next),
        .count_next (count_next),
        .ctl        (ctl),
        .at         (at)
    );

    // row of cells, each fed by its front and back neighbors where it has them
    logic signed [VALUE_W-1:0] cell_data [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [VALUE_W-1:0] left_in;
        logic signed [VALUE_W-1:0] right_in;

        if (i == 0) begin : g_first
            assign left_in = ctl.value;
        end else begin : g_mid_l
            assign left_in = cell_data[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_in = cell_data[i];
        end else begin : g_mid_r
            assign right_in = cell_data[i+1];
        end

        ple_cell #(
            .IDX_W (IDX_W),
            .INDEX (i)
        ) u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .at         (at),
            .left_data  (left_in),
            .right_data (right_in),
            .data       (cell_data[i])
        );
    end

    always_comb begin
        valid_next = valid_reg;
        if (fire) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    // result payload, loaded with each accepted command
    always_ff @(posedge aclk) begin
        if (fire) begin
            status_reg <= status_next;
            length_reg <= LEN_W'(count_next);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(M_DATA_W - STATUS_W - LEN_W){1'b0}}, length_reg, status_reg};

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("list length above capacity");

    a_len_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (length_reg == LEN_W'(count_reg)))
        else $error("reported length differs from list length");

    a_full_only_at_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && status_next == ST_FULL) |-> (count_reg == CNT_W'(CAPACITY)))
        else $error("full reported below capacity");

    a_reject_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && status_next != ST_DONE) |=> $stable(count_reg))
        else $error("rejected command changed the length");

    a_no_change_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(count_reg))
        else $error("length changed without a command");
`endif

endmodule
